>>> hw/rtl/three_line_edge_run_capture_unit_defines.svh
// Assertion macros for the three-line edge run capture unit.
`ifndef THREE_LINE_EDGE_RUN_CAPTURE_UNIT_DEFINES_SVH
`define THREE_LINE_EDGE_RUN_CAPTURE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TLEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlec assertion failed");
`define TLEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlec assertion failed");
`else
`define TLEC_ASSERT_SAME(label, ante, cons)
`define TLEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/tlec_pkg.sv
// Shared types and constants of the three-line edge run capture unit.
package tlec_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int LINE_COUNT = 3;

  localparam int CODE_W = 3;
  localparam int COUNT_W = 12;
  localparam int LINE_FILL_W = 12;
  localparam int LIMIT_W = 12;
  localparam int READ_INDEX_W = 11;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] LINE_STROBE = 2'd0;
  localparam logic [1:0] LINE_CLOCK = 2'd1;
  localparam logic [1:0] LINE_DATA = 2'd2;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0] opcode;
    logic strobe_level;
    logic clock_level;
    logic data_level;
    logic [1:0] read_line;
    logic [READ_INDEX_W-1:0] read_index;
  } tlec_cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] entry_code;
    logic [COUNT_W-1:0] entry_count;
    logic [LINE_FILL_W-1:0] line_fill;
    logic capture_done;
  } tlec_result_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [COUNT_W-1:0] count;
  } tlec_entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic level;
    logic read;
    logic read_in_range;
    logic [READ_INDEX_W-1:0] read_index;
  } tlec_line_ctl_t;

endpackage

>>> hw/rtl/tlec_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tlec_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/tlec_line.sv
// Run tracker and run table of one sampled line.
module tlec_line (
  input  logic                    clk,
  input  logic                    rst,
  input  tlec_pkg::tlec_line_ctl_t ctl,
  output logic [tlec_pkg::FILL_W-1:0] fill,
  output tlec_pkg::tlec_entry_t   entry
);
  import tlec_pkg::*;

  logic              prev;
  logic [FILL_W-1:0] idx;
  logic              written;
  logic [COUNT_W-1:0] cur_count;
  logic              rd_hit;

  logic               room;
  logic [COUNT_W-1:0] base_count;
  logic [COUNT_W-1:0] new_count;
  logic               we;
  tlec_entry_t        wentry;
  tlec_entry_t        rentry;
  logic [FILL_W-1:0]  rd_ext;

  assign room = idx < FILL_W'(TABLE_DEPTH);
  assign base_count = written ? cur_count : '0;
  assign new_count = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
  assign we = ctl.sample && room;
  assign wentry.code = {1'b0, prev, ctl.level};
  assign wentry.count = new_count;
  assign rd_ext = FILL_W'(ctl.read_index);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prev <= 1'b0;
      idx <= '0;
      written <= 1'b0;
    end else if (ctl.sample) begin
      prev <= ctl.level;
      if (room) begin
        cur_count <= new_count;
        if (ctl.level != prev) begin
          idx <= idx + 1'b1;
          written <= 1'b0;
        end else begin
          written <= 1'b1;
        end
      end
    end
  end

  // Entries past the fill point were not written since the last clear.
  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rd_hit <= ctl.read_in_range && ((rd_ext < idx) || ((rd_ext == idx) && written));
    end
  end

  tlec_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(CODE_W + COUNT_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(idx[ADDR_W-1:0]),
    .wdata(wentry),
    .re   (ctl.read),
    .raddr(ADDR_W'(ctl.read_index)),
    .rdata(rentry)
  );

  assign fill = idx;

  always_comb begin
    if (rd_hit) begin
      entry = rentry;
    end else begin
      entry.code = CODE_EMPTY;
      entry.count = '0;
    end
  end

endmodule

>>> hw/rtl/three_line_edge_run_capture_unit.sv
// Top level of the three-line edge run capture unit.
//
//  channel   | ports                         | transfer
//  ----------+-------------------------------+-----------------------------
//  command   | start, busy, cmd              | start high while busy low
//  result    | result_valid, result          | one cycle, result_valid high
//  config    | cfg_wr_en, cfg_wr_data        | cfg_wr_en high
//
// A new command is taken in every cycle.
// A read returns its result in the cycle after the transfer, from the
// synchronous table read. Samples write the current run entry straight
// from registers, so no read-modify-write stall arises.
// Reset and clear take effect at once through the per-line fill indices.
// The receiver cannot stall; busy stays low.
module three_line_edge_run_capture_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tlec_pkg::tlec_cmd_t           cmd,
  output logic                          result_valid,
  output tlec_pkg::tlec_result_t        result,
  input  logic                          cfg_wr_en,
  input  logic [tlec_pkg::LIMIT_W-1:0]  cfg_wr_data
);
  import tlec_pkg::*;
  `include "three_line_edge_run_capture_unit_defines.svh"

  logic [LIMIT_W-1:0] capture_limit;
  logic [COUNT_W-1:0] samples_taken;
  logic [1:0]         res_line;
  logic [LINE_FILL_W-1:0] res_fill;
  logic               res_done;

  logic           accept;
  logic           done;
  logic           do_sample;
  logic           do_read;
  logic           do_clear;
  logic [LINE_COUNT-1:0] levels;
  logic [FILL_W-1:0] fills [LINE_COUNT];
  tlec_entry_t    entries [LINE_COUNT];
  tlec_line_ctl_t ctls [LINE_COUNT];
  logic [LINE_FILL_W-1:0] sel_fill;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign done = samples_taken >= capture_limit;
  assign do_sample = accept && (cmd.opcode == OP_SAMPLE) && !done;
  assign do_read = accept && (cmd.opcode == OP_READ);
  assign do_clear = accept && (cmd.opcode == OP_CLEAR);
  assign levels = {cmd.data_level, cmd.clock_level, cmd.strobe_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_limit <= LIMIT_W'(TABLE_DEPTH);
    end else if (cfg_wr_en) begin
      capture_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      samples_taken <= '0;
    end else if (do_sample && (samples_taken != COUNT_MAX)) begin
      samples_taken <= samples_taken + 1'b1;
    end
  end

  for (genvar g = 0; g < LINE_COUNT; g++) begin : g_line
    always_comb begin
      ctls[g].clear = do_clear;
      ctls[g].sample = do_sample;
      ctls[g].level = levels[g];
      ctls[g].read = do_read;
      ctls[g].read_in_range = 32'(cmd.read_index) < TABLE_DEPTH;
      ctls[g].read_index = cmd.read_index;
    end

    tlec_line u_line (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctls[g]),
      .fill (fills[g]),
      .entry(entries[g])
    );
  end

  always_comb begin
    unique case (cmd.read_line)
      LINE_STROBE: sel_fill = LINE_FILL_W'(fills[0]);
      LINE_CLOCK:  sel_fill = LINE_FILL_W'(fills[1]);
      LINE_DATA:   sel_fill = LINE_FILL_W'(fills[2]);
      default:     sel_fill = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      res_line <= cmd.read_line;
      res_fill <= sel_fill;
      res_done <= done;
    end
  end

  always_comb begin
    result.line_fill = res_fill;
    result.capture_done = res_done;
    unique case (res_line)
      LINE_STROBE: begin
        result.entry_code = entries[0].code;
        result.entry_count = entries[0].count;
      end
      LINE_CLOCK: begin
        result.entry_code = entries[1].code;
        result.entry_count = entries[1].count;
      end
      LINE_DATA: begin
        result.entry_code = entries[2].code;
        result.entry_count = entries[2].count;
      end
      default: begin
        result.entry_code = CODE_EMPTY;
        result.entry_count = '0;
      end
    endcase
  end

  `TLEC_ASSERT_NEXT(a_read_gives_result, do_read, result_valid)
  `TLEC_ASSERT_NEXT(a_no_result_otherwise, !do_read, !result_valid)
  `TLEC_ASSERT_SAME(a_fill_bounded, 1'b1, (fills[0] <= FILL_W'(TABLE_DEPTH)) && (fills[1] <= FILL_W'(TABLE_DEPTH)) && (fills[2] <= FILL_W'(TABLE_DEPTH)))
  `TLEC_ASSERT_NEXT(a_done_holds_count, accept && (cmd.opcode == OP_SAMPLE) && done, $stable(samples_taken))

endmodule
